@@ design/ipdt_pkg.sv @@
`timescale 1ns / 1ps

package ipdt_pkg;

    // fixed field widths
    localparam int WORD_W      = 16;
    localparam int HALF_W      = 16;
    localparam int PHASE_LEN_W = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // default sizing of the frame engine
    localparam int WORD_BITS_DEF  = 16;
    localparam int TIMER_BITS_DEF = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_HALF_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARK_TICKS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SPACE_TICKS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MARK_TICKS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TICKS         = 3'd4;

    // register reset values
    localparam logic [HALF_W-1:0]      RST_CARRIER_HALF_PERIOD = 16'd13;
    localparam logic [PHASE_LEN_W-1:0] RST_START_MARK_TICKS    = 24'd2400;
    localparam logic [PHASE_LEN_W-1:0] RST_START_SPACE_TICKS   = 24'd600000;
    localparam logic [PHASE_LEN_W-1:0] RST_LONG_MARK_TICKS     = 24'd1200;
    localparam logic [PHASE_LEN_W-1:0] RST_SHORT_TICKS         = 24'd600;

    typedef struct packed {
        logic [HALF_W-1:0]      carrier_half_period;
        logic [PHASE_LEN_W-1:0] start_mark_ticks;
        logic [PHASE_LEN_W-1:0] start_space_ticks;
        logic [PHASE_LEN_W-1:0] long_mark_ticks;
        logic [PHASE_LEN_W-1:0] short_ticks;
    } t_cfg;

    typedef struct packed {
        logic ir_level;
        logic mark_active;
        logic busy_res;
        logic send_rejected;
    } t_result;

endpackage

@@ design/ipdt_cfg_regs.sv @@
`timescale 1ns / 1ps

module ipdt_cfg_regs import ipdt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.carrier_half_period <= RST_CARRIER_HALF_PERIOD;
            r_cfg.start_mark_ticks    <= RST_START_MARK_TICKS;
            r_cfg.start_space_ticks   <= RST_START_SPACE_TICKS;
            r_cfg.long_mark_ticks     <= RST_LONG_MARK_TICKS;
            r_cfg.short_ticks         <= RST_SHORT_TICKS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CARRIER_HALF_PERIOD: begin
                    r_cfg.carrier_half_period <= i_cfg_data[HALF_W-1:0];
                end
                CFG_START_MARK_TICKS: begin
                    r_cfg.start_mark_ticks <= i_cfg_data[PHASE_LEN_W-1:0];
                end
                CFG_START_SPACE_TICKS: begin
                    r_cfg.start_space_ticks <= i_cfg_data[PHASE_LEN_W-1:0];
                end
                CFG_LONG_MARK_TICKS: begin
                    r_cfg.long_mark_ticks <= i_cfg_data[PHASE_LEN_W-1:0];
                end
                CFG_SHORT_TICKS: begin
                    r_cfg.short_ticks <= i_cfg_data[PHASE_LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ design/ipdt_seq.sv @@
`timescale 1ns / 1ps

module ipdt_seq import ipdt_pkg::*; #(
    parameter int WORD_BITS  = WORD_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_command,
    input  logic [WORD_W-1:0] i_word,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    localparam int BI_W = $clog2(WORD_BITS + 1);

    typedef enum logic [4:0] {
        PH_IDLE        = 5'b00001,
        PH_START_MARK  = 5'b00010,
        PH_START_SPACE = 5'b00100,
        PH_BIT_MARK    = 5'b01000,
        PH_BIT_SPACE   = 5'b10000
    } t_phase;

    t_phase                r_phase,         n_phase;
    logic [TIMER_BITS-1:0] r_phase_timer,   n_phase_timer;
    logic [BI_W-1:0]       r_bit_index,     n_bit_index;
    logic [WORD_BITS-1:0]  r_shift_word,    n_shift_word;
    logic [HALF_W-1:0]     r_carrier_timer, n_carrier_timer;
    logic                  r_carrier_level, n_carrier_level;

    logic [HALF_W-1:0]      half;
    logic [HALF_W-1:0]      ct_inc;
    logic [PHASE_LEN_W-1:0] len_raw;
    logic [TIMER_BITS-1:0]  len_cut;
    logic [TIMER_BITS-1:0]  len;
    logic [TIMER_BITS-1:0]  pt_inc;
    logic [BI_W-1:0]        bi_inc;
    logic                   rejected;
    logic                   mark;

    // a zero half period toggles every tick
    assign half   = (i_cfg.carrier_half_period == '0) ? HALF_W'(1) : i_cfg.carrier_half_period;
    assign ct_inc = r_carrier_timer + HALF_W'(1);
    assign pt_inc = r_phase_timer + TIMER_BITS'(1);
    assign bi_inc = r_bit_index + BI_W'(1);

    // length of the current phase, zero counts as one tick
    always_comb begin
        case (r_phase)
            PH_START_MARK:  len_raw = i_cfg.start_mark_ticks;
            PH_START_SPACE: len_raw = i_cfg.start_space_ticks;
            PH_BIT_MARK:    len_raw = r_shift_word[0] ? i_cfg.long_mark_ticks
                                                      : i_cfg.short_ticks;
            PH_BIT_SPACE:   len_raw = i_cfg.short_ticks;
            default:        len_raw = PHASE_LEN_W'(1);
        endcase
    end

    assign len_cut = TIMER_BITS'(len_raw);
    assign len     = (len_cut == '0) ? TIMER_BITS'(1) : len_cut;

    always_comb begin
        n_phase         = r_phase;
        n_phase_timer   = r_phase_timer;
        n_bit_index     = r_bit_index;
        n_shift_word    = r_shift_word;
        n_carrier_timer = r_carrier_timer;
        n_carrier_level = r_carrier_level;
        rejected        = 1'b0;
        if (i_take) begin
            if (i_command) begin
                if (r_phase == PH_IDLE) begin
                    n_shift_word  = WORD_BITS'(i_word);
                    n_phase       = PH_START_MARK;
                    n_phase_timer = '0;
                    n_bit_index   = '0;
                end else begin
                    rejected = 1'b1;
                end
            end else begin
                // free-running carrier
                if (ct_inc >= half) begin
                    n_carrier_timer = '0;
                    n_carrier_level = ~r_carrier_level;
                end else begin
                    n_carrier_timer = ct_inc;
                end
                if (r_phase != PH_IDLE) begin
                    if (pt_inc < len) begin
                        n_phase_timer = pt_inc;
                    end else begin
                        n_phase_timer = '0;
                        case (r_phase)
                            PH_START_MARK: begin
                                n_phase = PH_START_SPACE;
                            end
                            PH_START_SPACE: begin
                                n_phase     = PH_BIT_MARK;
                                n_bit_index = '0;
                            end
                            PH_BIT_MARK: begin
                                n_phase = PH_BIT_SPACE;
                            end
                            PH_BIT_SPACE: begin
                                n_shift_word = r_shift_word >> 1;
                                n_bit_index  = bi_inc;
                                n_phase      = (bi_inc >= BI_W'(WORD_BITS)) ? PH_IDLE
                                                                            : PH_BIT_MARK;
                            end
                            default: begin
                                n_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
            end
        end
    end

    // result reflects the state after this request
    assign mark                   = (n_phase == PH_START_MARK) || (n_phase == PH_BIT_MARK);
    assign o_result.ir_level      = mark & n_carrier_level;
    assign o_result.mark_active   = mark;
    assign o_result.busy_res      = (n_phase != PH_IDLE);
    assign o_result.send_rejected = rejected;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_phase_timer   <= '0;
            r_bit_index     <= '0;
            r_shift_word    <= '0;
            r_carrier_timer <= '0;
            r_carrier_level <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_phase_timer   <= n_phase_timer;
            r_bit_index     <= n_bit_index;
            r_shift_word    <= n_shift_word;
            r_carrier_timer <= n_carrier_timer;
            r_carrier_level <= n_carrier_level;
        end
    end

endmodule

@@ design/ipdt_out_skid.sv @@
`timescale 1ns / 1ps

module ipdt_out_skid import ipdt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_data,
    output logic    o_stall,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_stall
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;

    assign o_stall = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || !i_stall) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_valid) begin
            r_skid <= i_data;
        end
    end

endmodule

@@ design/ir_pulse_distance_transmitter.sv @@
`timescale 1ns / 1ps

// ir remote transmitter, pulse-distance style frames
// input channel (i_in_valid / o_in_stall): one request per tick or send;
//   i_command 0 advances time by one tick, 1 starts sending i_word
//   (ignored and flagged in o_send_rejected while a frame is running)
// output channel (o_out_valid / i_out_stall): exactly one result per request,
//   carrying pin level, mark envelope, busy and reject flags after the request
// config channel (i_cfg_valid / o_cfg_ready): register index plus data,
//   always ready; write only while idle; indexes above 4 are dropped
// each result is registered in the result register, or in the skid register while the receiver stalls
// throughput: one request per cycle while o_in_stall is low, set by the state update
//   between the frame state registers and the result register
// when the receiver stalls, the pending result holds and one more request
//   is taken into a skid register; o_in_stall then rises until it drains
// reset (synchronous, active low): idle, timers cleared, carrier low,
//   registers back to their defaults, no result pending

module ir_pulse_distance_transmitter import ipdt_pkg::*; #(
    parameter int WORD_BITS  = WORD_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_command,
    input  logic [WORD_W-1:0]     i_word,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_ir_level,
    output logic                  o_mark_active,
    output logic                  o_busy_res,
    output logic                  o_send_rejected,
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_result seq_result;
    t_result out_result;
    logic    take;

    // request taken whenever the skid slot is free
    assign take = i_in_valid & ~o_in_stall;

    ipdt_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // frame sequencer and carrier, one request per cycle while the skid slot is free
    ipdt_seq #(
        .WORD_BITS  (WORD_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_command (i_command),
        .i_word    (i_word),
        .i_cfg     (cfg),
        .o_result  (seq_result)
    );

    // result register with skid slot
    ipdt_out_skid u_out_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (take),
        .i_data  (seq_result),
        .o_stall (o_in_stall),
        .o_valid (o_out_valid),
        .o_data  (out_result),
        .i_stall (i_out_stall)
    );

    assign o_ir_level      = out_result.ir_level;
    assign o_mark_active   = out_result.mark_active;
    assign o_busy_res      = out_result.busy_res;
    assign o_send_rejected = out_result.send_rejected;

endmodule

@@ sim/ir_pulse_distance_transmitter_tb.sv @@
`timescale 1ns / 1ps

module ir_pulse_distance_transmitter_tb;
    import ipdt_pkg::*;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SEND = 1'b1;

    // cycles with no transfer on any channel before the run is declared hung
    localparam int HANG_LIMIT = 2000;
    // receiver and sender take no random breaks inside this window of cycles
    localparam int CALM_FROM = 900;
    localparam int CALM_TO   = 1500;

    typedef struct packed {
        logic              command;
        logic [WORD_W-1:0] word;
    } t_ir_req;

    typedef enum logic [4:0] {
        FR_IDLE      = 5'b00001,
        FR_LEAD_MARK = 5'b00010,
        FR_LEAD_GAP  = 5'b00100,
        FR_DATA_MARK = 5'b01000,
        FR_DATA_GAP  = 5'b10000
    } t_frame_phase;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  command = CMD_TICK;
    logic [WORD_W-1:0]     word = '0;
    logic                  o_out_valid;
    logic                  out_stall = 1'b0;
    logic                  o_ir_level;
    logic                  o_mark_active;
    logic                  o_busy_res;
    logic                  o_send_rejected;
    logic                  cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ir_pulse_distance_transmitter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (command),
        .i_word          (word),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_ir_level      (o_ir_level),
        .o_mark_active   (o_mark_active),
        .o_busy_res      (o_busy_res),
        .o_send_rejected (o_send_rejected),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_ir_req tx_requests[$];
    t_result pin_expect[$];
    int      errors = 0;
    int      cyc_count = 0;

    // frame engine mirror, reset values
    t_cfg               regs = '{RST_CARRIER_HALF_PERIOD, RST_START_MARK_TICKS,
                                 RST_START_SPACE_TICKS, RST_LONG_MARK_TICKS,
                                 RST_SHORT_TICKS};
    t_frame_phase       fr_phase = FR_IDLE;
    logic [PHASE_LEN_W-1:0] phase_count = '0;
    logic [4:0]         bit_cnt = '0;
    logic [WORD_W-1:0]  shift_reg = '0;
    logic [HALF_W-1:0]  carr_count = '0;
    logic               carr_lvl = 1'b0;

    // zero-length phases last one tick
    function automatic logic [PHASE_LEN_W-1:0] span_of(input logic [PHASE_LEN_W-1:0] v);
        return (v == '0) ? PHASE_LEN_W'(1) : v;
    endfunction

    function automatic logic [PHASE_LEN_W-1:0] phase_span();
        case (fr_phase)
            FR_LEAD_MARK: return span_of(regs.start_mark_ticks);
            FR_LEAD_GAP:  return span_of(regs.start_space_ticks);
            FR_DATA_MARK: return span_of(shift_reg[0] ? regs.long_mark_ticks
                                                      : regs.short_ticks);
            FR_DATA_GAP:  return span_of(regs.short_ticks);
            default:      return PHASE_LEN_W'(1);
        endcase
    endfunction

    // one time unit: carrier always runs, frame timer only while sending
    function automatic void advance_tick();
        logic [HALF_W-1:0] half;
        half = (regs.carrier_half_period == '0) ? HALF_W'(1) : regs.carrier_half_period;
        carr_count = carr_count + HALF_W'(1);
        if (carr_count >= half) begin
            carr_count = '0;
            carr_lvl = ~carr_lvl;
        end
        if (fr_phase != FR_IDLE) begin
            if ({1'b0, phase_count} + 1 < {1'b0, phase_span()}) begin
                phase_count = phase_count + 1'b1;
            end else begin
                phase_count = '0;
                case (fr_phase)
                    FR_LEAD_MARK: fr_phase = FR_LEAD_GAP;
                    FR_LEAD_GAP: begin
                        fr_phase = FR_DATA_MARK;
                        bit_cnt = '0;
                    end
                    FR_DATA_MARK: fr_phase = FR_DATA_GAP;
                    FR_DATA_GAP: begin
                        shift_reg = shift_reg >> 1;
                        bit_cnt = bit_cnt + 1'b1;
                        fr_phase = (bit_cnt >= WORD_BITS_DEF) ? FR_IDLE : FR_DATA_MARK;
                    end
                    default: fr_phase = FR_IDLE;
                endcase
            end
        end
    endfunction

    // pin state after one request
    function automatic t_result pin_after(input t_ir_req req);
        t_result r;
        logic    mark;
        r.send_rejected = 1'b0;
        if (req.command == CMD_SEND) begin
            if (fr_phase == FR_IDLE) begin
                shift_reg = req.word;
                fr_phase = FR_LEAD_MARK;
                phase_count = '0;
                bit_cnt = '0;
            end else begin
                r.send_rejected = 1'b1;
            end
        end else begin
            advance_tick();
        end
        mark = (fr_phase == FR_LEAD_MARK) || (fr_phase == FR_DATA_MARK);
        r.ir_level = mark & carr_lvl;
        r.mark_active = mark;
        r.busy_res = (fr_phase != FR_IDLE);
        return r;
    endfunction

    function automatic bit take_break();
        if (cyc_count >= CALM_FROM && cyc_count < CALM_TO) return 1'b0;
        return $urandom_range(0, 99) < 30;
    endfunction

    always @(posedge i_clk) begin
        cyc_count <= cyc_count + 1;
    end

    // request driver: payload holds while stalled
    always @(posedge i_clk) begin
        t_ir_req nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (in_valid) begin
                pin_expect.push_back(pin_after('{command, word}));
            end
            if (tx_requests.size() != 0 && !take_break()) begin
                nxt = tx_requests.pop_front();
                in_valid <= 1'b1;
                command <= nxt.command;
                word <= nxt.word;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    task automatic check_bit(input string name, input logic want, input logic got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0b actual %0b", $time, name, want, got);
        end
    endtask

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (pin_expect.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result expected none actual %b", $time,
                             {o_ir_level, o_mark_active, o_busy_res, o_send_rejected});
                end else begin
                    want = pin_expect.pop_front();
                    check_bit("ir_level", want.ir_level, o_ir_level);
                    check_bit("mark_active", want.mark_active, o_mark_active);
                    check_bit("busy_res", want.busy_res, o_busy_res);
                    check_bit("send_rejected", want.send_rejected, o_send_rejected);
                end
            end
            out_stall <= take_break();
        end
    end

    // hang detection: no transfer on any channel for too long
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= HANG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic push_ticks(input int n);
        repeat (n) tx_requests.push_back('{CMD_TICK, WORD_W'($urandom)});
    endtask

    task automatic push_send(input logic [WORD_W-1:0] w);
        tx_requests.push_back('{CMD_SEND, w});
    endtask

    // mostly ticks with the odd send, so frames run to the end with random words
    // and some sends land mid-frame
    task automatic push_random(input int n);
        repeat (n) begin
            tx_requests.push_back('{($urandom_range(0, 99) < 5) ? CMD_SEND : CMD_TICK,
                                    WORD_W'($urandom)});
        end
    endtask

    // sampled on the falling edge so every update of the rising edge has landed
    task automatic wait_drained();
        do @(negedge i_clk);
        while (tx_requests.size() != 0 || in_valid || pin_expect.size() != 0);
    endtask

    // drain, then tick until the frame is over so registers can change
    task automatic settle();
        wait_drained();
        while (fr_phase != FR_IDLE) begin
            push_ticks(40);
            wait_drained();
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_CARRIER_HALF_PERIOD: regs.carrier_half_period = data[HALF_W-1:0];
            CFG_START_MARK_TICKS:    regs.start_mark_ticks = data;
            CFG_START_SPACE_TICKS:   regs.start_space_ticks = data;
            CFG_LONG_MARK_TICKS:     regs.long_mark_ticks = data;
            CFG_SHORT_TICKS:         regs.short_ticks = data;
            default: ;
        endcase
    endtask

    task automatic write_timing(input logic [CFG_DATA_W-1:0] half,
                                input logic [CFG_DATA_W-1:0] lead_mark,
                                input logic [CFG_DATA_W-1:0] lead_gap,
                                input logic [CFG_DATA_W-1:0] one_mark,
                                input logic [CFG_DATA_W-1:0] short_len);
        write_reg(CFG_CARRIER_HALF_PERIOD, half);
        write_reg(CFG_START_MARK_TICKS, lead_mark);
        write_reg(CFG_START_SPACE_TICKS, lead_gap);
        write_reg(CFG_LONG_MARK_TICKS, one_mark);
        write_reg(CFG_SHORT_TICKS, short_len);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default carrier toggles while idle
        push_ticks(14);
        settle();

        // zero lengths and zero half period all act as one tick
        write_timing('0, '0, '0, '0, '0);
        push_send(16'hFFFF);
        push_send(16'h5555);
        push_ticks(3);
        settle();
        push_send(16'h0000);
        push_ticks(2);
        settle();

        // writes to unused indexes must not disturb anything
        for (int k = CFG_SHORT_TICKS + 1; k < 2 ** CFG_IDX_W; k++)
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));

        // upper data bits of the half period are dropped
        write_timing(24'hFF0003, 24'd1, 24'd2, 24'd3, 24'd1);
        push_random(400);
        settle();

        write_timing(24'd1, 24'd3, 24'd5, 24'd6, 24'd2);
        push_random(450);
        settle();

        write_timing(CFG_DATA_W'($urandom_range(0, 9)), CFG_DATA_W'($urandom_range(0, 8)),
                     CFG_DATA_W'($urandom_range(0, 8)), CFG_DATA_W'($urandom_range(0, 8)),
                     CFG_DATA_W'($urandom_range(0, 8)));
        push_random(450);
        settle();

        // largest settings: the frame stays in its lead mark to the end of the run
        write_timing(24'h00FFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        push_ticks(6);
        push_send(16'hFFFF);
        push_ticks(12);
        push_send(WORD_W'($urandom));
        push_ticks(12);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
